// ===== rtl/sorted_table_binary_search_macros.svh =====
// ----------------------------------------------------------------------------
// Sorted table binary search: assertion macros
// Concurrent assertion shorthands for the RTL of the block, used by the search engine.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define STBS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stbs assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define STBS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stbs assertion failed");

`else

`define STBS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define STBS_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/stbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search: package
// Item types, command codes, engine states and shared constants.
// ----------------------------------------------------------------------------
package stbs_pkg;

    // Default number of table entries.
    localparam int DEFAULT_TABLE_DEPTH = 1024;

    // Fixed field widths of the item format and of the entry count.
    localparam int ENTRY_INDEX_W = 10;
    localparam int DATA_W        = 32;
    localparam int COUNT_W       = 11;

    // Depth of the command queue between the front end and the engine.
    localparam int CMD_QUEUE_DEPTH = 2;

    // Request type codes carried in the input item.
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // Input item.
    typedef struct packed {
        logic                            req_type;
        logic [ENTRY_INDEX_W-1:0]        entry_index;
        logic signed [DATA_W-1:0]        data_value;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic                            found;
        logic [ENTRY_INDEX_W-1:0]        found_index;
    } t_out_item;

    // Classified command handed from the front end to the engine.
    typedef enum logic {
        CMD_WRITE,
        CMD_SEARCH
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind                       kind;
        logic [ENTRY_INDEX_W-1:0]        entry_index;
        logic signed [DATA_W-1:0]        data_value;
    } t_cmd;

    // Search engine states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_WAIT,
        ST_DONE
    } t_eng_state;

endpackage

// ===== rtl/stbs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/stbs_front.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search: front end
// Accepts input items, drops writes beyond the table, and queues commands
// for the search engine.
// ----------------------------------------------------------------------------
module stbs_front #(
    parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  stbs_pkg::t_in_item i_in,
    output logic              o_cmd_valid,
    output stbs_pkg::t_cmd    o_cmd,
    input  logic              i_cmd_pop
);
    import stbs_pkg::*;

    localparam int PTR_W  = (CMD_QUEUE_DEPTH > 1) ? $clog2(CMD_QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(CMD_QUEUE_DEPTH + 1);

    t_cmd              r_queue [CMD_QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wptr;
    logic [PTR_W-1:0]  r_rptr;
    logic [FILL_W-1:0] r_fill;
    logic [PTR_W-1:0]  n_wptr;
    logic [PTR_W-1:0]  n_rptr;
    logic [FILL_W-1:0] n_fill;

    logic in_xfer;
    logic idx_ok;
    logic push;
    t_cmd cmd_new;

    // Classify the incoming item; a write outside the table is dropped.
    assign o_in_stall = (r_fill == FILL_W'(CMD_QUEUE_DEPTH));
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign idx_ok     = (32'(i_in.entry_index) < 32'(TABLE_DEPTH));
    assign push       = in_xfer && ((i_in.req_type == REQ_SEARCH) || idx_ok);

    always_comb begin
        cmd_new.kind        = (i_in.req_type == REQ_SEARCH) ? CMD_SEARCH : CMD_WRITE;
        cmd_new.entry_index = i_in.entry_index;
        cmd_new.data_value  = i_in.data_value;
    end

    // Queue pointers and fill level.
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_fill = r_fill;
        if (push) begin
            n_wptr = (r_wptr == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (i_cmd_pop) begin
            n_rptr = (r_rptr == PTR_W'(CMD_QUEUE_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (push && !i_cmd_pop) begin
            n_fill = r_fill + 1'b1;
        end else if (!push && i_cmd_pop) begin
            n_fill = r_fill - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_fill <= n_fill;
        end
    end

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_queue[r_wptr] <= cmd_new;
        end
    end

    assign o_cmd_valid = (r_fill != '0);
    assign o_cmd       = r_queue[r_rptr];

endmodule

// ===== rtl/stbs_engine.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search: search engine
// Holds the table memory and the entry count, performs table writes and
// runs the halving search, each probe reading the table in ST_PROBE and comparing in ST_WAIT.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_macros.svh"

module stbs_engine #(
    parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [stbs_pkg::COUNT_W-1:0]      i_cfg_wdata,
    input  logic                              i_cmd_valid,
    input  stbs_pkg::t_cmd                    i_cmd,
    output logic                              o_cmd_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output stbs_pkg::t_out_item               o_out
);
    import stbs_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    t_eng_state               r_state;
    t_eng_state               n_state;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         r_left;
    logic [CNT_W-1:0]         n_left;
    logic [CNT_W-1:0]         r_hi;
    logic [CNT_W-1:0]         n_hi;
    logic [ADDR_W-1:0]        r_mid;
    logic [ADDR_W-1:0]        n_mid;
    logic signed [DATA_W-1:0] r_target;
    logic signed [DATA_W-1:0] n_target;
    logic                     r_found;
    logic                     n_found;
    logic [ADDR_W-1:0]        r_idx;
    logic [ADDR_W-1:0]        n_idx;
    logic                     r_out_valid;
    logic                     n_out_valid;
    t_out_item                r_out;
    t_out_item                n_out;

    logic                     ram_we;
    logic [ADDR_W-1:0]        ram_waddr;
    logic                     ram_re;
    logic [DATA_W-1:0]        ram_rdata;
    logic [CNT_W-1:0]         span_m1;
    logic [ADDR_W-1:0]        mid_c;
    logic signed [DATA_W-1:0] probe;

    // Entry count, saturated to the table depth when written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= (32'(i_cfg_wdata) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                             : CNT_W'(i_cfg_wdata);
        end
    end

    // Midpoint of the live range [left, hi), where hi is one past right.
    assign span_m1 = r_hi - r_left - 1'b1;
    assign mid_c   = ADDR_W'(r_left + (span_m1 >> 1));
    assign probe   = $signed(ram_rdata);

    // Table memory.
    stbs_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.data_value),
        .i_re    (ram_re),
        .i_raddr (mid_c),
        .o_rdata (ram_rdata)
    );

    assign ram_waddr = ADDR_W'(i_cmd.entry_index);

    // Next state, search bookkeeping and the result register.
    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_target    = r_target;
        n_found     = r_found;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_cmd_pop   = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.kind == CMD_WRITE) begin
                        ram_we = 1'b1;
                    end else begin
                        n_left   = '0;
                        n_hi     = r_count;
                        n_target = i_cmd.data_value;
                        n_state  = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                if (r_left < r_hi) begin
                    ram_re  = 1'b1;
                    n_mid   = mid_c;
                    n_state = ST_WAIT;
                end else begin
                    n_found = 1'b0;
                    n_idx   = '0;
                    n_state = ST_DONE;
                end
            end
            ST_WAIT: begin
                if (probe == r_target) begin
                    n_found = 1'b1;
                    n_idx   = r_mid;
                    n_state = ST_DONE;
                end else if (probe < r_target) begin
                    n_left  = CNT_W'(r_mid) + 1'b1;
                    n_state = ST_PROBE;
                end else begin
                    n_hi    = CNT_W'(r_mid);
                    n_state = ST_PROBE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid       = 1'b1;
                    n_out.found       = r_found;
                    n_out.found_index = ENTRY_INDEX_W'(r_idx);
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left   <= n_left;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_target <= n_target;
        r_found  <= n_found;
        r_idx    <= n_idx;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // A probe always lies inside a nonempty live range.
    `STBS_ASSERT_IMP(a_probe_in_range, i_clk, i_rst_n, r_state == ST_WAIT, (r_left < r_hi) && (CNT_W'(r_mid) < r_hi) && (CNT_W'(r_mid) >= r_left))
    // The live range never reaches past the entry count.
    `STBS_ASSERT_IMP(a_range_bounded, i_clk, i_rst_n, r_state == ST_PROBE, r_hi <= r_count)
    // A compare is always followed by another probe or by the result.
    `STBS_ASSERT_NXT(a_wait_exit, i_clk, i_rst_n, r_state == ST_WAIT, (r_state == ST_PROBE) || (r_state == ST_DONE))
    // A finished result is only dropped into a free output register.
    `STBS_ASSERT_NXT(a_no_overwrite, i_clk, i_rst_n, r_out_valid && i_out_stall, r_out_valid && $stable(r_out))

endmodule

// ===== rtl/sorted_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search: top level
// A search runs one probe per pass through the probe and wait states, around the table RAM's
// registered read; the number of probes P is at most floor(log2(entry_count)) + 1
// (11 for 1024 entries). A hit goes to the result state from the wait state, a miss from
// the probe state. The engine takes no new command until the result is registered;
// a write produces no result.
// Reset clears the queue, the engine and entry_count; table contents stay undefined.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
    parameter int TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [stbs_pkg::COUNT_W-1:0]  i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  stbs_pkg::t_in_item            i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output stbs_pkg::t_out_item           o_out
);
    import stbs_pkg::*;

    logic cmd_valid;
    logic cmd_pop;
    t_cmd cmd;

    // Front end: accept, classify and queue.
    stbs_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_pop   (cmd_pop)
    );

    // Back end: table writes and the search itself.
    stbs_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

// ===== tb/sv/tb_sorted_table_binary_search.sv =====
// ----------------------------------------------------------------------------
// Sorted table binary search: self-checking testbench
// Loads the table through write transfers, sets the entry count between
// phases and checks every search answer against a behavioral binary search
// over a shadow copy of the table, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_sorted_table_binary_search;
    timeunit 1ns;
    timeprecision 1ps;

    import stbs_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int DRAIN_CYCLES = 48;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int PHASES       = 11;
    localparam int HOLD_PHASE   = 7;
    localparam int SPINE_LEN    = 11;

    localparam logic signed [DATA_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

    // How the live part of the table is reloaded at the start of a phase.
    typedef enum logic [1:0] {
        FILL_KEEP,
        FILL_SORTED,
        FILL_SHUFFLED
    } t_fill_mode;

    // Phase plan: entry count, reload style and number of random items.
    int         plan_count [PHASES] = '{1, 2, 3, 4, 7, 16, 64, 120, 0, 33, 100};
    t_fill_mode plan_fill  [PHASES] = '{FILL_SORTED, FILL_SORTED, FILL_SORTED,
                                        FILL_SHUFFLED, FILL_SORTED, FILL_SORTED,
                                        FILL_SORTED, FILL_SORTED, FILL_KEEP, FILL_SORTED,
                                        FILL_KEEP};
    int         plan_items [PHASES] = '{15, 15, 15, 20, 20, 25, 30, 60, 15, 25, 30};

    // Slots on the rightmost probe path of a full table.
    int         spine_slots [SPINE_LEN] = '{511, 767, 895, 959, 991, 1007, 1015, 1019,
                                            1021, 1022, 1023};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [COUNT_W-1:0]   i_cfg_wdata = '0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out;

    // Stimulus side.
    t_in_item             pending_requests [$];
    int                   stim_entries [DEPTH];
    int                   stim_limit = 0;
    int                   n_queued = 0;
    logic                 hold_armed = 1'b0;

    // Prediction side.
    logic signed [DATA_W-1:0] shadow_entries [DEPTH];
    logic [COUNT_W-1:0]   shadow_count = '0;
    t_out_item            awaited_lookups [$];
    int                   n_accepted = 0;
    int                   n_errors = 0;

    int                   in_gap = 0;
    int                   stall_run = 0;
    logic                 stall_on = 1'b0;
    int                   hold_left = 0;
    logic                 hold_done = 1'b0;
    int                   cycle_count = 0;

    sorted_table_binary_search i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Binary search over the shadow table, probing exactly as the block does.
    function automatic t_out_item lookup_result(input logic signed [DATA_W-1:0] target);
        t_out_item answer;
        int        lo;
        int        hi;
        int        mid;
        answer = '0;
        lo = 0;
        hi = (shadow_count > DEPTH) ? DEPTH - 1 : int'(shadow_count) - 1;
        while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_entries[mid] == target) begin
                answer.found = 1'b1;
                answer.found_index = mid[ENTRY_INDEX_W-1:0];
                return answer;
            end
            if (shadow_entries[mid] < target)
                lo = mid + 1;
            else
                hi = mid - 1;
        end
        return answer;
    endfunction

    // Mostly targets that sit in the live table, some neighbors and outsiders.
    function automatic int pick_target();
        int roll;
        int value;
        roll = $urandom_range(99);
        if (stim_limit > 0 && roll < 70) begin
            value = stim_entries[$urandom_range(stim_limit - 1)];
            if (roll >= 55)
                value = roll[0] ? value + 1 : value - 1;
        end else if (roll < 85) begin
            value = int'($urandom());
        end else begin
            case ($urandom_range(3))
                0: value = VALUE_MIN;
                1: value = VALUE_MAX;
                2: value = 0;
                default: value = -1;
            endcase
        end
        return value;
    endfunction

    task automatic queue_request(input logic kind, input logic [ENTRY_INDEX_W-1:0] slot,
                                 input logic signed [DATA_W-1:0] value);
        t_in_item item;
        item.req_type    = kind;
        item.entry_index = slot;
        item.data_value  = value;
        if (kind == REQ_WRITE)
            stim_entries[slot] = value;
        pending_requests.push_back(item);
        n_queued++;
    endtask

    // Waits until every transfer is taken and answered, then lets writes drain.
    task automatic wait_idle();
        do @(posedge i_clk);
        while (n_accepted != n_queued || awaited_lookups.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_entry_count(input logic [COUNT_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        shadow_count = value;
        stim_limit   = (value > DEPTH) ? DEPTH : int'(value);
        i_cfg_we    <= 1'b0;
    endtask

    // Main sequence: reset, directed cases, then the phase plan.
    initial begin
        int vals [$];
        int slot;
        int phase;
        int k;
        logic signed [DATA_W-1:0] value;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty table straight after reset, then extremes with one and two entries.
        queue_request(REQ_SEARCH, 10'h3ff, VALUE_MAX);
        queue_request(REQ_WRITE, 10'd0, VALUE_MIN);
        queue_request(REQ_WRITE, 10'd1, 32'sd0);
        queue_request(REQ_WRITE, 10'h3ff, VALUE_MAX);
        write_entry_count(11'd1);
        queue_request(REQ_SEARCH, 10'd0, VALUE_MIN);
        queue_request(REQ_SEARCH, 10'd0, VALUE_MAX);
        queue_request(REQ_SEARCH, 10'd0, -32'sd1);
        write_entry_count(11'd2);
        queue_request(REQ_SEARCH, 10'd0, 32'sd0);
        queue_request(REQ_SEARCH, 10'd0, VALUE_MIN);
        queue_request(REQ_SEARCH, 10'd0, 32'sd5);
        queue_request(REQ_SEARCH, 10'd0, VALUE_MIN + 1);

        for (phase = 0; phase < PHASES; phase++) begin
            write_entry_count(plan_count[phase][COUNT_W-1:0]);

            // Reload the live entries; sorted fills carry duplicates, and the extremes when at least 16 are live.
            if (plan_fill[phase] != FILL_KEEP) begin
                vals.delete();
                for (slot = 0; slot < stim_limit; slot++)
                    vals.push_back((slot > 0 && $urandom_range(9) == 0) ? vals[slot - 1]
                                                                       : int'($urandom()));
                if (plan_fill[phase] == FILL_SORTED) begin
                    vals.sort();
                    if (stim_limit >= 16) begin
                        vals[0] = VALUE_MIN;
                        vals[stim_limit - 1] = VALUE_MAX;
                    end
                end
                for (slot = 0; slot < stim_limit; slot++)
                    queue_request(REQ_WRITE, slot[ENTRY_INDEX_W-1:0], vals[slot]);
            end

            // First and last live entries, and both ends of the value range.
            if (stim_limit > 0) begin
                queue_request(REQ_SEARCH, 10'd0, stim_entries[0]);
                queue_request(REQ_SEARCH, 10'h3ff, stim_entries[stim_limit - 1]);
            end
            queue_request(REQ_SEARCH, 10'd0, VALUE_MIN);
            queue_request(REQ_SEARCH, 10'd0, VALUE_MAX);

            // Random part: mostly searches, some writes that keep or break the order.
            for (k = 0; k < plan_items[phase]; k++) begin
                if ($urandom_range(99) < 80) begin
                    queue_request(REQ_SEARCH, 10'($urandom_range(DEPTH - 1)), pick_target());
                end else begin
                    slot = $urandom_range(DEPTH - 1);
                    if (slot < stim_limit && $urandom_range(1) == 1)
                        value = stim_entries[slot];
                    else
                        value = $urandom();
                    queue_request(REQ_WRITE, slot[ENTRY_INDEX_W-1:0], value);
                end
            end

            // In the hold phase, stop reading results while searches keep coming.
            if (phase == HOLD_PHASE) begin
                wait (n_accepted + 100 >= n_queued);
                hold_armed = 1'b1;
            end
        end

        // Counts past the depth: only the rightmost probe path is loaded, in ascending
        // order, so searches for those values or above them stay on written slots.
        for (k = 0; k < SPINE_LEN; k++)
            queue_request(REQ_WRITE, spine_slots[k][ENTRY_INDEX_W-1:0], 32'sd1000 * (k + 1));
        write_entry_count(11'd2047);
        for (k = 0; k < SPINE_LEN; k++)
            queue_request(REQ_SEARCH, 10'd0, 32'sd1000 * (k + 1));
        queue_request(REQ_SEARCH, 10'd0, VALUE_MAX);
        write_entry_count(11'd1500);
        queue_request(REQ_SEARCH, 10'd0, 32'sd1000 * SPINE_LEN);
        queue_request(REQ_SEARCH, 10'd0, 32'sd1000);

        wait_idle();
        if (n_errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Request driver: applies accepted transfers to the shadow state.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            in_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                if (i_in.req_type == REQ_WRITE)
                    shadow_entries[i_in.entry_index] = i_in.data_value;
                else
                    awaited_lookups.push_back(lookup_result(i_in.data_value));
                n_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (in_gap > 0 || pending_requests.size() == 0) begin
                    if (in_gap > 0)
                        in_gap--;
                    i_in_valid <= 1'b0;
                end else begin
                    i_in       <= pending_requests.pop_front();
                    i_in_valid <= 1'b1;
                    case ($urandom_range(19))
                        0, 1:          in_gap = $urandom_range(10, 40);
                        2, 3, 4, 5, 6,
                        7, 8:          in_gap = $urandom_range(1, 3);
                        default:       in_gap = 0;
                    endcase
                end
            end
        end
    end

    // Result back-pressure: short stalls, calm stretches, rare long stalls and one hold.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_run = 0;
            hold_left = 0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else begin
            if (stall_run == 0) begin
                case ($urandom_range(19))
                    0, 1, 2:           begin stall_on = 1'b0; stall_run = $urandom_range(30, 80); end
                    3, 4, 5, 6, 7, 8:  begin stall_on = 1'b1; stall_run = $urandom_range(1, 3); end
                    9:                 begin stall_on = 1'b1; stall_run = $urandom_range(10, 40); end
                    default:           begin stall_on = 1'b0; stall_run = $urandom_range(1, 4); end
                endcase
            end
            stall_run--;
            i_out_stall <= stall_on;
        end
    end

    // Result monitor: each accepted transfer is checked against the oldest answer.
    always @(posedge i_clk) begin : result_monitor
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_lookups.size() == 0) begin
                $display("%0t: unexpected result, expected none, got found=%0b index=%0d",
                         $time, o_out.found, o_out.found_index);
                n_errors++;
            end else begin
                want = awaited_lookups.pop_front();
                if (o_out.found !== want.found) begin
                    $display("%0t: found flag, expected %0b, got %0b",
                             $time, want.found, o_out.found);
                    n_errors++;
                end
                if (o_out.found_index !== want.found_index) begin
                    $display("%0t: found index, expected %0d, got %0d",
                             $time, want.found_index, o_out.found_index);
                    n_errors++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule
